### rtl/byte_budget_lru_cache_defines.svh
// ----------------------------------------------------------------------------
// Byte budget LRU cache assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BBL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bbl assertion failed");
`define BBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bbl assertion failed");
`else
`define BBL_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/bbl_pkg.sv
// ----------------------------------------------------------------------------
// Byte budget LRU cache package
// Transaction types, operation codes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbl_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 24;
    localparam int PL_W    = 64;
    localparam int LIMIT_W = 28;
    localparam int TOTAL_W = 29;
    localparam int ECNT_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 28'hFFFFFFF;
    localparam logic [ECNT_W-1:0]  ECNT_MAX    = 5'd31;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_EVICT = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  tile_key;
        logic [SIZE_W-1:0] tile_size;
        logic [PL_W-1:0]   tile_payload;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [PL_W-1:0]    found_payload;
        logic [ECNT_W-1:0]  evicted_count;
        logic [LIMIT_W-1:0] total_bytes;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/bbl_store.sv
// ----------------------------------------------------------------------------
// Byte budget LRU cache slot store
// Key, size and payload memories, one write port and registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbl_store #(
    parameter int ENTRIES = bbl_pkg::ENTRIES_DEF,
    parameter int KB      = bbl_pkg::KEY_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  wire logic [KB-1:0]              i_wr_key,
    input  wire logic [bbl_pkg::SIZE_W-1:0] i_wr_size,
    input  wire logic [bbl_pkg::PL_W-1:0]   i_wr_payload,
    input  wire logic [$clog2(ENTRIES)-1:0] i_key_addr,
    input  wire logic [$clog2(ENTRIES)-1:0] i_size_addr,
    input  wire logic [$clog2(ENTRIES)-1:0] i_pl_addr,
    output logic      [KB-1:0]              o_key,
    output logic      [bbl_pkg::SIZE_W-1:0] o_size,
    output logic      [bbl_pkg::PL_W-1:0]   o_payload
);

    logic [KB-1:0]              mem_key  [ENTRIES];
    logic [bbl_pkg::SIZE_W-1:0] mem_size [ENTRIES];
    logic [bbl_pkg::PL_W-1:0]   mem_pl   [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_key[i_wr_addr]  <= i_wr_key;
            mem_size[i_wr_addr] <= i_wr_size;
            mem_pl[i_wr_addr]   <= i_wr_payload;
        end
        o_key     <= mem_key[i_key_addr];
        o_size    <= mem_size[i_size_addr];
        o_payload <= mem_pl[i_pl_addr];
    end

endmodule

`default_nettype wire

### rtl/byte_budget_lru_cache.sv
// ----------------------------------------------------------------------------
// Byte budget LRU cache
// Each transaction runs a key scan and a decide step, put an insert step too,
// plus a size read and a removal per removed entry; the key scan reads one slot per cycle.
// One transaction in flight; next accepted once the result is registered.
// Reset: synchronous active low; cache empty, limit at its largest value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "byte_budget_lru_cache_defines.svh"

module byte_budget_lru_cache #(
    parameter int ENTRIES  = bbl_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = bbl_pkg::KEY_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [bbl_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bbl_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bbl_pkg::t_out_item               o_out_data
);

    localparam int KB = (KEY_BITS < bbl_pkg::KEY_W) ? KEY_BITS : bbl_pkg::KEY_W;
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_RDSZ   = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                   r_state;
    logic [bbl_pkg::LIMIT_W-1:0]  r_limit;
    logic [ENTRIES-1:0]           r_valid;
    logic [IW-1:0]                r_rank [ENTRIES];
    logic [CW-1:0]                r_count;
    logic [bbl_pkg::TOTAL_W-1:0]  r_total;
    bbl_pkg::t_in_item            r_item;
    logic [CW-1:0]                r_idx;
    logic [IW-1:0]                r_qidx;
    logic                         r_qv;
    logic                         r_found;
    logic [IW-1:0]                r_fslot;
    logic [IW-1:0]                r_rslot;
    logic                         r_ins;
    logic                         r_hit;
    logic [bbl_pkg::ECNT_W-1:0]   r_ecnt;
    logic                         r_ovalid;
    bbl_pkg::t_out_item           r_out;

    logic [KB-1:0]                key_q;
    logic [bbl_pkg::SIZE_W-1:0]   size_q;
    logic [bbl_pkg::PL_W-1:0]     pl_q;
    logic [IW-1:0]                lru_slot;
    logic [IW-1:0]                free_slot;
    logic [IW-1:0]                lru_rank;
    logic                         over;
    logic                         wr_en;

    assign lru_rank = IW'(r_count - CW'(1));
    assign over     = (r_total > {1'b0, r_limit}) && (r_count != '0);
    assign wr_en    = (r_state == S_INSERT);

    always_comb begin
        lru_slot  = '0;
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IW'(i);
            end
            if (r_valid[i] && (r_rank[i] == lru_rank)) begin
                lru_slot = IW'(i);
            end
        end
    end

    bbl_store #(
        .ENTRIES (ENTRIES),
        .KB      (KB)
    ) u_store (
        .i_clk        (i_clk),
        .i_wr_en      (wr_en),
        .i_wr_addr    (free_slot),
        .i_wr_key     (r_item.tile_key[KB-1:0]),
        .i_wr_size    (r_item.tile_size),
        .i_wr_payload (r_item.tile_payload),
        .i_key_addr   (r_idx[IW-1:0]),
        .i_size_addr  (r_rslot),
        .i_pl_addr    (r_fslot),
        .o_key        (key_q),
        .o_size       (size_q),
        .o_payload    (pl_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= bbl_pkg::LIMIT_RESET;
            r_valid  <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_qv     <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            r_qv   <= (r_state == S_SCAN) && (r_idx < FULL);
            r_qidx <= r_idx[IW-1:0];
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_ins   <= 1'b0;
                        r_hit   <= 1'b0;
                        r_ecnt  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_qv && r_valid[r_qidx] && (key_q == r_item.tile_key[KB-1:0])) begin
                        r_found <= 1'b1;
                        r_fslot <= r_qidx;
                    end
                    if (r_idx == FULL) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_DECIDE: begin
                    case (r_item.operation)
                        bbl_pkg::OP_PUT: begin
                            if (r_found) begin
                                r_found <= 1'b0;
                                r_rslot <= r_fslot;
                                r_state <= S_RDSZ;
                            end else if (!r_ins && (r_count == FULL)) begin
                                r_rslot <= lru_slot;
                                r_state <= S_RDSZ;
                            end else if (!r_ins) begin
                                r_state <= S_INSERT;
                            end else if (over) begin
                                r_rslot <= lru_slot;
                                r_state <= S_RDSZ;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        bbl_pkg::OP_GET: begin
                            if (r_found) begin
                                for (int i = 0; i < ENTRIES; i++) begin
                                    if (r_valid[i] && (r_rank[i] < r_rank[r_fslot])) begin
                                        r_rank[i] <= r_rank[i] + IW'(1);
                                    end
                                end
                                r_rank[r_fslot] <= '0;
                                r_hit <= 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                        bbl_pkg::OP_EVICT: begin
                            if (over) begin
                                r_rslot <= lru_slot;
                                if (r_ecnt != bbl_pkg::ECNT_MAX) begin
                                    r_ecnt <= r_ecnt + bbl_pkg::ECNT_W'(1);
                                end
                                r_state <= S_RDSZ;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_RDSZ: begin
                    r_state <= S_REMOVE;
                end
                S_REMOVE: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (r_rank[i] > r_rank[r_rslot])) begin
                            r_rank[i] <= r_rank[i] - IW'(1);
                        end
                    end
                    r_rank[r_rslot]  <= '0;
                    r_valid[r_rslot] <= 1'b0;
                    r_count <= r_count - CW'(1);
                    r_total <= r_total - bbl_pkg::TOTAL_W'(size_q);
                    r_state <= S_DECIDE;
                end
                S_INSERT: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i]) begin
                            r_rank[i] <= r_rank[i] + IW'(1);
                        end
                    end
                    r_rank[free_slot]  <= '0;
                    r_valid[free_slot] <= 1'b1;
                    r_count <= r_count + CW'(1);
                    r_total <= r_total + bbl_pkg::TOTAL_W'(r_item.tile_size);
                    r_ins   <= 1'b1;
                    r_state <= S_DECIDE;
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ovalid || i_out_ready)) begin
            r_out.hit           <= r_hit;
            r_out.found_payload <= r_hit ? pl_q : '0;
            r_out.evicted_count <= r_ecnt;
            r_out.total_bytes   <= r_total[bbl_pkg::LIMIT_W-1:0];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `BBL_ASSERT_SAME(a_count_matches, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_valid)))
    `BBL_ASSERT_SAME(a_total_fits, i_clk, i_rst_n, r_state == S_IDLE, !r_total[bbl_pkg::TOTAL_W-1])
    `BBL_ASSERT_NEXT(a_remove_frees, i_clk, i_rst_n, r_state == S_REMOVE, r_count == $past(r_count) - CW'(1))

endmodule

`default_nettype wire
